### hw/rtl/scf_pkg.sv
// Shared constants and types for the CRC-8 frame reassembler.
package scf_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int PTR_W        = 6;
  localparam int FILL_W       = 7;
  localparam int POS_W        = 6;

  localparam logic [7:0] SYNC_A   = 8'hAA;
  localparam logic [7:0] SYNC_B   = 8'h55;
  localparam logic [7:0] INV_MASK = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Minimum bytes before the header can be judged, and fixed frame overhead.
  localparam int MIN_HDR    = 7;
  localparam int FRAME_OVHD = 8;
  localparam int MAX_LEN_LO = BUFFER_BYTES - FRAME_OVHD;

  // Header offsets.
  localparam int OFF_SYNC  = 0;
  localparam int OFF_CMD   = 1;
  localparam int OFF_NCMD  = 2;
  localparam int OFF_LEN_L = 5;
  localparam int OFF_LEN_H = 6;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // One accepted frame waiting to be sent out.
  typedef struct packed {
    logic [PTR_W-1:0] start;
    logic [POS_W-1:0] last_pos;
    logic             run_last;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic idle;
  } back_stat_t;

endpackage

### hw/rtl/scf_in_if.sv
// Input byte channel: received byte and flush request.
interface scf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       flush;

  modport source (output valid, output rx_byte, output flush, input ready);
  modport sink   (input valid, input rx_byte, input flush, output ready);
endinterface

### hw/rtl/scf_out_if.sv
// Output channel: one byte of an accepted frame with its position flags.
interface scf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [5:0] byte_position;
  logic       frame_end;
  logic       run_end;

  modport source (output valid, output frame_byte, output byte_position,
                  output frame_end, output run_end, input ready);
  modport sink   (input valid, input frame_byte, input byte_position,
                  input frame_end, input run_end, output ready);
endinterface

### hw/rtl/sync_crc8_frame_reassembler_core.sv
// Top level of the length-prefixed CRC-8 frame reassembler.
// Usage:
//   byte_in carries one received byte per request (rx_byte) and a flush bit.
//   A flush request empties the buffer and gives no output.
//   Each other byte is appended to a 64-byte buffer, which is then rescanned:
//   junk and bad candidates are dropped one byte at a time, and every frame
//   whose header and CRC-8 check pass is sent on frame_out byte by byte with
//   its position, frame_end on the check byte and run_end on the last byte
//   caused by the current input request.
// Timing:
//   The scanner streams buffer bytes at one per cycle through a registered
//   read port unless a full descriptor queue holds it, and each dropped
//   byte restarts the candidate. The emitter reads each output byte from
//   the buffer, then loads it into the output register, and issues no new
//   read while one is still in flight. byte_in is ready again once the scan
//   has ended and every frame has been read out of the buffer; only the
//   final byte may still sit in the output register. A stalled receiver
//   holds the output register, then the descriptor queue, then the scanner,
//   with no loss.
// Reset (rst, synchronous): the buffer is empty and no output is pending.
module sync_crc8_frame_reassembler_core (
  input  logic      clk,
  input  logic      rst,
  scf_in_if.sink    byte_in,
  scf_out_if.source frame_out
);

  scf_pkg::q_push_t    q_push;
  scf_pkg::q_stat_t    q_stat;
  scf_pkg::desc_t      q_desc;
  scf_pkg::rd_req_t    rd_req;
  scf_pkg::back_stat_t back_stat;
  logic                q_pop;
  logic [7:0]          rd_data;

  scf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .back_stat (back_stat),
    .rd_req    (rd_req),
    .rd_data   (rd_data)
  );

  scf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .pop       (q_pop),
    .head_desc (q_desc),
    .stat      (q_stat)
  );

  scf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_desc    (q_desc),
    .q_pop     (q_pop),
    .rd_req    (rd_req),
    .rd_data   (rd_data),
    .stat      (back_stat),
    .frame_out (frame_out)
  );

endmodule

### hw/rtl/scf_front.sv
// Front end: byte buffer, append, and the header/CRC rescan of buffered bytes.
module scf_front (
  input  logic                clk,
  input  logic                rst,
  scf_in_if.sink              byte_in,
  input  scf_pkg::q_stat_t    q_stat,
  output scf_pkg::q_push_t    q_push,
  input  scf_pkg::back_stat_t back_stat,
  input  scf_pkg::rd_req_t    rd_req,
  output logic [7:0]          rd_data
);

  typedef enum logic {F_IDLE, F_SCAN} state_t;
  typedef enum logic [2:0] {ACT_ISSUE, ACT_DROP, ACT_FRAME, ACT_DONE} act_t;

  state_t state;
  act_t   act;

  logic [7:0] byte_store [scf_pkg::BUFFER_BYTES];

  logic [scf_pkg::PTR_W-1:0]  head;
  logic [scf_pkg::FILL_W-1:0] fill;
  logic [scf_pkg::POS_W-1:0]  off;
  logic [scf_pkg::POS_W-1:0]  poff;
  logic                       pend;
  logic [7:0]                 rda;
  logic [7:0]                 crc;
  logic [7:0]                 cmd;
  logic [7:0]                 len_lo;
  logic [scf_pkg::POS_W-1:0]  last_pos;
  logic                       hold_valid;
  logic [scf_pkg::PTR_W-1:0]  hold_start;
  logic [scf_pkg::POS_W-1:0]  hold_last;

  logic                       accept;
  logic                       stall;
  logic                       rd_en_a;
  logic [scf_pkg::PTR_W-1:0]  rd_addr_a;
  logic [scf_pkg::PTR_W-1:0]  wr_addr;
  logic [7:0]                 crc_next;
  logic [scf_pkg::POS_W-1:0]  last_pos_next;
  logic                       oversize;

  function automatic logic [7:0] crc8_byte(input logic [7:0] v);
    logic [7:0] c;
    c = v;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ scf_pkg::CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  assign byte_in.ready = (state == F_IDLE) && q_stat.empty && back_stat.idle;
  assign accept        = byte_in.valid && byte_in.ready;
  // with the buffer full, fill[5:0] is zero and the write lands on the oldest byte
  assign wr_addr       = head + fill[scf_pkg::PTR_W-1:0];
  assign rd_addr_a     = head + off;

  assign crc_next      = crc8_byte(((poff == scf_pkg::POS_W'(scf_pkg::OFF_SYNC)) ? 8'h00 : crc)
                                   ^ rda);
  assign oversize      = (rda != 8'h00) || (len_lo > 8'(scf_pkg::MAX_LEN_LO));
  assign last_pos_next = scf_pkg::POS_W'(len_lo) + scf_pkg::POS_W'(scf_pkg::FRAME_OVHD - 1);

  always_comb begin
    act = ACT_ISSUE;
    if (fill == '0) begin
      act = ACT_DONE;
    end else if (pend) begin
      if (poff == scf_pkg::POS_W'(scf_pkg::OFF_SYNC)) begin
        if (rda != scf_pkg::SYNC_A && rda != scf_pkg::SYNC_B) begin
          act = ACT_DROP;
        end else if (fill < scf_pkg::FILL_W'(scf_pkg::MIN_HDR)) begin
          act = ACT_DONE;
        end
      end else if (poff == scf_pkg::POS_W'(scf_pkg::OFF_NCMD)) begin
        if ((cmd ^ scf_pkg::INV_MASK) != rda) act = ACT_DROP;
      end else if (poff == scf_pkg::POS_W'(scf_pkg::OFF_LEN_H)) begin
        if (oversize) begin
          act = ACT_DROP;
        end else if ({1'b0, last_pos_next} >= fill) begin
          act = ACT_DONE;
        end
      end else if (poff > scf_pkg::POS_W'(scf_pkg::OFF_LEN_H) && poff == last_pos) begin
        act = (crc == rda) ? ACT_FRAME : ACT_DROP;
      end
    end
  end

  // a frame is held back until the scan knows whether another one follows
  assign stall = hold_valid && q_stat.full && (act == ACT_FRAME || act == ACT_DONE);
  assign q_push.valid         = (state == F_SCAN) && hold_valid && !stall &&
                                (act == ACT_FRAME || act == ACT_DONE);
  assign q_push.desc.start    = hold_start;
  assign q_push.desc.last_pos = hold_last;
  assign q_push.desc.run_last = (act == ACT_DONE);
  assign rd_en_a              = (state == F_SCAN) && (act == ACT_ISSUE);

  always_ff @(posedge clk) begin
    if (accept && !byte_in.flush) byte_store[wr_addr] <= byte_in.rx_byte;
    if (rd_en_a) rda <= byte_store[rd_addr_a];
    if (rd_req.en) rd_data <= byte_store[rd_req.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      head       <= '0;
      fill       <= '0;
      pend       <= 1'b0;
      off        <= '0;
      hold_valid <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            if (byte_in.flush) begin
              head <= '0;
              fill <= '0;
            end else begin
              if (fill == scf_pkg::FILL_W'(scf_pkg::BUFFER_BYTES)) begin
                head <= head + 1'b1;
              end else begin
                fill <= fill + 1'b1;
              end
              off   <= '0;
              pend  <= 1'b0;
              state <= F_SCAN;
            end
          end
        end
        F_SCAN: begin
          unique case (act)
            ACT_ISSUE: begin
              off  <= off + 1'b1;
              poff <= off;
              pend <= 1'b1;
              if (pend) begin
                crc <= crc_next;
                if (poff == scf_pkg::POS_W'(scf_pkg::OFF_CMD))   cmd      <= rda;
                if (poff == scf_pkg::POS_W'(scf_pkg::OFF_LEN_L)) len_lo   <= rda;
                if (poff == scf_pkg::POS_W'(scf_pkg::OFF_LEN_H)) last_pos <= last_pos_next;
              end
            end
            ACT_DROP: begin
              head <= head + 1'b1;
              fill <= fill - 1'b1;
              off  <= '0;
              pend <= 1'b0;
            end
            ACT_FRAME: begin
              if (!stall) begin
                hold_valid <= 1'b1;
                hold_start <= head;
                hold_last  <= last_pos;
                head       <= head + last_pos + 1'b1;
                fill       <= fill - scf_pkg::FILL_W'(last_pos) - 1'b1;
                off        <= '0;
                pend       <= 1'b0;
              end
            end
            ACT_DONE: begin
              if (!stall) begin
                hold_valid <= 1'b0;
                state      <= F_IDLE;
              end
            end
            default: ;
          endcase
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/scf_queue.sv
// Small FIFO of accepted-frame descriptors between scanner and emitter.
module scf_queue (
  input  logic             clk,
  input  logic             rst,
  input  scf_pkg::q_push_t push,
  input  logic             pop,
  output scf_pkg::desc_t   head_desc,
  output scf_pkg::q_stat_t stat
);

  scf_pkg::desc_t entries [scf_pkg::QDEPTH];

  logic [scf_pkg::QPTR_W-1:0] wptr;
  logic [scf_pkg::QPTR_W-1:0] rptr;
  logic [scf_pkg::QCNT_W-1:0] count;
  logic                       do_push;
  logic                       do_pop;

  assign stat.full  = (count == scf_pkg::QCNT_W'(scf_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push.valid && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_desc  = entries[rptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wptr] <= push.desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/scf_back.sv
// Back end: reads accepted frames out of the buffer and drives the output register.
module scf_back (
  input  logic                clk,
  input  logic                rst,
  input  scf_pkg::q_stat_t    q_stat,
  input  scf_pkg::desc_t      q_desc,
  output logic                q_pop,
  output scf_pkg::rd_req_t    rd_req,
  input  logic [7:0]          rd_data,
  output scf_pkg::back_stat_t stat,
  scf_out_if.source           frame_out
);

  logic                      busy;
  logic [scf_pkg::PTR_W-1:0] start;
  logic [scf_pkg::POS_W-1:0] last_pos;
  logic                      run_last;
  logic [scf_pkg::POS_W-1:0] off;

  // request in flight: data lands in the output register next cycle
  logic                      rf;
  logic [scf_pkg::POS_W-1:0] rf_pos;
  logic                      rf_fend;
  logic                      rf_rend;

  logic                      ov;
  logic                      issue;
  logic                      at_last;

  assign q_pop       = !busy && !q_stat.empty;
  assign at_last     = (off == last_pos);
  assign issue       = busy && !rf && (!ov || frame_out.ready);
  assign rd_req.en   = issue;
  assign rd_req.addr = start + off;
  assign stat.idle   = !busy && !rf;
  assign frame_out.valid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rf   <= 1'b0;
      ov   <= 1'b0;
    end else begin
      if (q_pop) begin
        busy     <= 1'b1;
        start    <= q_desc.start;
        last_pos <= q_desc.last_pos;
        run_last <= q_desc.run_last;
        off      <= '0;
      end else if (issue) begin
        if (at_last) busy <= 1'b0;
        else off <= off + 1'b1;
      end

      rf <= issue;
      if (issue) begin
        rf_pos  <= off;
        rf_fend <= at_last;
        rf_rend <= at_last && run_last;
      end

      if (rf) begin
        ov                      <= 1'b1;
        frame_out.frame_byte    <= rd_data;
        frame_out.byte_position <= rf_pos;
        frame_out.frame_end     <= rf_fend;
        frame_out.run_end       <= rf_rend;
      end else if (frame_out.ready) begin
        ov <= 1'b0;
      end
    end
  end

endmodule
